// ----- design/lrs_pkg.sv -----
`default_nettype none

package lrs_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TRACK_LIMIT = 10000;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_FULL   = 2'd1,
    ST_SERVED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RES_ADDED,
    RES_FULL,
    RES_EMPTY,
    RES_NONE,
    RES_SERVED
  } res_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DECIDE,
    S_SHIFT
  } lrs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic add_wr;
    logic scan_init;
    logic scan_rd;
    logic pick_load;
    logic shift_rd;
    logic occ_dec;
    logic res_load;
    res_e res_sel;
  } lrs_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_add;
    logic occ_zero;
    logic occ_full;
    logic scan_last;
    logic shift_last;
    logic found_any;
  } lrs_stat_t;

endpackage

`default_nettype wire

// ----- design/lrs_ctrl.sv -----
`default_nettype none

module lrs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire lrs_pkg::lrs_stat_t stat_i,
  output lrs_pkg::lrs_ctrl_t     ctrl_o,
  output logic                   busy_o
);
  import lrs_pkg::*;

  lrs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && !stat_i.in_add && !stat_i.occ_zero) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = stat_i.found_any ? S_SHIFT : S_IDLE;
      end
      S_SHIFT: begin
        if (stat_i.shift_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.res_sel = RES_ADDED;
    busy_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.capture = 1'b1;
          if (stat_i.in_add) begin
            ctrl_o.res_load = 1'b1;
            if (stat_i.occ_full) begin
              ctrl_o.res_sel = RES_FULL;
            end else begin
              ctrl_o.add_wr = 1'b1;
            end
          end else if (stat_i.occ_zero) begin
            ctrl_o.res_load = 1'b1;
            ctrl_o.res_sel  = RES_EMPTY;
          end else begin
            ctrl_o.scan_init = 1'b1;
          end
        end
      end
      S_SCAN: begin
        ctrl_o.scan_rd = 1'b1;
      end
      S_WAIT: begin
      end
      S_DECIDE: begin
        ctrl_o.res_load = 1'b1;
        if (stat_i.found_any) begin
          ctrl_o.res_sel   = RES_SERVED;
          ctrl_o.pick_load = 1'b1;
        end else begin
          ctrl_o.res_sel = RES_NONE;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_last) begin
          ctrl_o.occ_dec = 1'b1;
        end else begin
          ctrl_o.shift_rd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/lrs_dp.sv -----
`default_nettype none

module lrs_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lrs_pkg::lrs_ctrl_t          ctrl_i,
  output lrs_pkg::lrs_stat_t               stat_o,
  input  wire logic                        func_i,
  input  wire logic [lrs_pkg::DATA_W-1:0]  req_id_i,
  input  wire logic [lrs_pkg::DATA_W-1:0]  track_i,
  input  wire logic [lrs_pkg::DATA_W-1:0]  current_track_i,
  input  wire logic signed [1:0]           direction_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [lrs_pkg::DATA_W-1:0]       out_id_o,
  output logic [lrs_pkg::DATA_W-1:0]       out_track_o,
  output logic                             reversed_o
);
  import lrs_pkg::*;

  localparam logic [DATA_W-1:0] LIMIT = DATA_W'(TRACK_LIMIT);

  // Queue storage, oldest request at index zero.
  logic [DATA_W-1:0] id_mem  [QUEUE_DEPTH];
  logic [DATA_W-1:0] trk_mem [QUEUE_DEPTH];

  logic [OCC_W-1:0]  occ_q;
  logic [IDX_W-1:0]  idx_q;
  logic              rv_scan_q, rv_shift_q, done_q;
  logic              fwd_found_q, rev_found_q;
  logic              dir0_q, up_q;
  logic [DATA_W-1:0] head_q;
  logic [DATA_W-1:0] rd_id_q, rd_trk_q;
  logic [IDX_W-1:0]  ridx_q, wr_addr_q;
  logic [DATA_W-1:0] fwd_best_q, rev_best_q;
  logic [IDX_W-1:0]  fwd_idx_q, rev_idx_q;
  logic [DATA_W-1:0] fwd_id_q, fwd_trk_q, rev_id_q, rev_trk_q;
  logic [1:0]        status_q;
  logic [DATA_W-1:0] out_id_q, out_trk_q;
  logic              rev_q;

  logic [OCC_W-1:0]  occ_m1;
  logic              at_last;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  wa, ra;
  logic [DATA_W-1:0] wd_id, wd_trk;
  logic              ge, le;
  logic [DATA_W-1:0] d_up, d_dn;
  logic              fwd_ok, rev_ok;
  logic [DATA_W-1:0] fwd_d, rev_d;
  logic              fwd_upd, rev_upd;

  assign occ_m1  = occ_q - OCC_W'(1);
  assign at_last = (OCC_W'(idx_q) == occ_m1);

  assign stat_o.in_add     = !func_i;
  assign stat_o.occ_zero   = (occ_q == '0);
  assign stat_o.occ_full   = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign stat_o.scan_last  = at_last || dir0_q;
  assign stat_o.shift_last = at_last;
  assign stat_o.found_any  = fwd_found_q || rev_found_q;

  // Single write port: new requests at the tail, or the compaction beat
  // that moves the entry read in the previous cycle down by one place.
  assign mem_we = ctrl_i.add_wr || rv_shift_q;
  assign wa     = ctrl_i.add_wr ? occ_q[IDX_W-1:0] : wr_addr_q;
  assign wd_id  = ctrl_i.add_wr ? req_id_i : rd_id_q;
  assign wd_trk = ctrl_i.add_wr ? track_i  : rd_trk_q;
  assign mem_re = ctrl_i.scan_rd || ctrl_i.shift_rd;
  assign ra     = ctrl_i.scan_rd ? idx_q : idx_q + IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      id_mem[wa]  <= wd_id;
      trk_mem[wa] <= wd_trk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_id_q  <= id_mem[ra];
      rd_trk_q <= trk_mem[ra];
    end
  end

  // Both search directions are evaluated in the same scan. An entry at the
  // head position has distance zero, so the oldest such one wins either way.
  assign ge   = (rd_trk_q >= head_q);
  assign le   = (rd_trk_q <= head_q);
  assign d_up = rd_trk_q - head_q;
  assign d_dn = head_q - rd_trk_q;

  always_comb begin
    if (dir0_q) begin
      fwd_ok = 1'b1;
      fwd_d  = '0;
      rev_ok = 1'b0;
      rev_d  = d_up;
    end else if (up_q) begin
      fwd_ok = ge;
      fwd_d  = d_up;
      rev_ok = le;
      rev_d  = d_dn;
    end else begin
      fwd_ok = le;
      fwd_d  = d_dn;
      rev_ok = ge;
      rev_d  = d_up;
    end
  end

  assign fwd_upd = rv_scan_q && fwd_ok && (fwd_d < fwd_best_q);
  assign rev_upd = rv_scan_q && rev_ok && (rev_d < rev_best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      idx_q       <= '0;
      rv_scan_q   <= 1'b0;
      rv_shift_q  <= 1'b0;
      done_q      <= 1'b0;
      fwd_found_q <= 1'b0;
      rev_found_q <= 1'b0;
      dir0_q      <= 1'b0;
      up_q        <= 1'b0;
    end else begin
      rv_scan_q  <= ctrl_i.scan_rd;
      rv_shift_q <= ctrl_i.shift_rd;
      done_q     <= ctrl_i.res_load;
      if (ctrl_i.capture) begin
        dir0_q <= (direction_i == 2'sb00);
        up_q   <= (direction_i == 2'sb01);
      end
      if (ctrl_i.add_wr) begin
        occ_q <= occ_q + OCC_W'(1);
      end else if (ctrl_i.occ_dec) begin
        occ_q <= occ_m1;
      end
      if (ctrl_i.scan_init) begin
        idx_q       <= '0;
        fwd_found_q <= 1'b0;
        rev_found_q <= 1'b0;
      end else begin
        if (fwd_upd) begin
          fwd_found_q <= 1'b1;
        end
        if (rev_upd) begin
          rev_found_q <= 1'b1;
        end
        if (ctrl_i.pick_load) begin
          idx_q <= fwd_found_q ? fwd_idx_q : rev_idx_q;
        end else if (ctrl_i.scan_rd || ctrl_i.shift_rd) begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      head_q <= current_track_i;
    end
    if (ctrl_i.scan_rd) begin
      ridx_q <= idx_q;
    end
    if (ctrl_i.shift_rd) begin
      wr_addr_q <= idx_q;
    end
    if (ctrl_i.scan_init) begin
      fwd_best_q <= LIMIT;
      rev_best_q <= LIMIT;
    end else begin
      if (fwd_upd) begin
        fwd_best_q <= fwd_d;
        fwd_idx_q  <= ridx_q;
        fwd_id_q   <= rd_id_q;
        fwd_trk_q  <= rd_trk_q;
      end
      if (rev_upd) begin
        rev_best_q <= rev_d;
        rev_idx_q  <= ridx_q;
        rev_id_q   <= rd_id_q;
        rev_trk_q  <= rd_trk_q;
      end
    end
    if (ctrl_i.res_load) begin
      out_id_q  <= '0;
      out_trk_q <= '0;
      rev_q     <= 1'b0;
      case (ctrl_i.res_sel)
        RES_ADDED: status_q <= ST_ADDED;
        RES_FULL:  status_q <= ST_FULL;
        RES_EMPTY: status_q <= ST_EMPTY;
        RES_NONE: begin
          status_q <= ST_EMPTY;
          rev_q    <= 1'b1;
        end
        RES_SERVED: begin
          status_q  <= ST_SERVED;
          out_id_q  <= fwd_found_q ? fwd_id_q  : rev_id_q;
          out_trk_q <= fwd_found_q ? fwd_trk_q : rev_trk_q;
          rev_q     <= !fwd_found_q;
        end
        default: status_q <= ST_EMPTY;
      endcase
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_id_o    = out_id_q;
  assign out_track_o = out_trk_q;
  assign reversed_o  = rev_q;

endmodule

`default_nettype wire

// ----- design/look_request_scheduler.sv -----
`default_nettype none

// LOOK request scheduler: a queue of up to QUEUE_DEPTH pending requests kept
// in arrival order, each an identifier and a target track.
// A command beat is taken at a rising edge where start_i is high and busy_o
// is low; func_i selects between adding a request and serving the next one.
// Every command gives exactly one result beat: done_o is high for one cycle
// with status_o, out_id_o, out_track_o and reversed_o valid alongside it.
// The receiver has no way to hold results off and needs none.
// Add, add to a full queue and serve from an empty queue answer in the cycle
// after the command and leave busy_o low, so commands may follow every cycle.
// Serving reads the queue one entry a cycle through the single read port of
// the storage, looking up and down at once, and then closes the gap by
// moving each later entry down one place a cycle. busy_o stays high until
// the search and any closing of the gap are done, and the next command can
// be taken once it is low again; the result beat comes after the scan, before
// the gap is closed. With direction zero only the oldest entry is read. Reset
// empties the queue; the stored entries are not cleared and need no pass.

module look_request_scheduler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        func_i,
  input  wire logic [lrs_pkg::DATA_W-1:0]  req_id_i,
  input  wire logic [lrs_pkg::DATA_W-1:0]  track_i,
  input  wire logic [lrs_pkg::DATA_W-1:0]  current_track_i,
  input  wire logic signed [1:0]           direction_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [lrs_pkg::DATA_W-1:0]       out_id_o,
  output logic [lrs_pkg::DATA_W-1:0]       out_track_o,
  output logic                             reversed_o
);
  import lrs_pkg::*;

  lrs_ctrl_t ctrl;
  lrs_stat_t stat;

  lrs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  lrs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .func_i          (func_i),
    .req_id_i        (req_id_i),
    .track_i         (track_i),
    .current_track_i (current_track_i),
    .direction_i     (direction_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .out_id_o        (out_id_o),
    .out_track_o     (out_track_o),
    .reversed_o      (reversed_o)
  );

  // An accepted command either answers in the next cycle or keeps the
  // block busy until its search has run.
  a_cmd_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> done_o || busy_o)
    else $error("accepted command neither answered nor started a search");

  // The block only becomes busy on the back of an accepted command.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy raised without a command");

  // Only a served request carries an identifier or a track.
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_SERVED |-> out_id_o == '0 && out_track_o == '0)
    else $error("payload present on a result that serves nothing");

  // The reversal flag never accompanies an add.
  a_rev_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && reversed_o |-> status_o == ST_SERVED || status_o == ST_EMPTY)
    else $error("reversal flagged on an add result");

endmodule

`default_nettype wire
